[src/ufrc_pkg.sv]
// Shared types and constants for the UART frame receiver with checksum.
// Used by the interfaces, the input queue, the frame parser and the top level.
package ufrc_pkg;

    localparam logic [7:0] SYNC_BYTE_0 = 8'hAA;
    localparam logic [7:0] SYNC_BYTE_1 = 8'h55;
    localparam int HDR_LEN = 6;
    localparam int CAP_DEPTH = 8;
    localparam int SUM_START = 2;
    localparam int CNT_W = 9;
    localparam logic [7:0] MAX_LEN_RESET = 8'd10;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_IDLE = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_qitem;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DRAIN  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_HDR   = 3'd1,
        ST_LEN_LONG  = 3'd2,
        ST_SUM_BAD   = 3'd3,
        ST_HDR_TMO   = 3'd4,
        ST_BODY_TMO  = 3'd5
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [7:0] version_hi;
        logic [7:0] version_lo;
        logic [7:0] frame_type;
        logic [7:0] payload_len;
        logic [7:0] power_byte;
        logic [7:0] level_byte;
        logic [7:0] received_sum;
        logic [7:0] computed_sum;
    } t_result;

    typedef struct packed {
        logic   valid;
        t_qitem item;
    } t_qhead;

endpackage

[src/ufrc_if.sv]
// Valid/ready channel interfaces for input items, results and configuration writes.
// Depends on ufrc_pkg for the status type.
interface ufrc_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;
    modport source (output valid, output action, output rx_byte, input ready);
    modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface ufrc_result_if;
    logic                 valid;
    logic                 ready;
    ufrc_pkg::t_status    status;
    logic [7:0]           version_hi;
    logic [7:0]           version_lo;
    logic [7:0]           frame_type;
    logic [7:0]           payload_len;
    logic [7:0]           power_byte;
    logic [7:0]           level_byte;
    logic [7:0]           received_sum;
    logic [7:0]           computed_sum;
    modport source (output valid, output status, output version_hi, output version_lo,
                    output frame_type, output payload_len, output power_byte,
                    output level_byte, output received_sum, output computed_sum,
                    input ready);
    modport sink (input valid, input status, input version_hi, input version_lo,
                  input frame_type, input payload_len, input power_byte,
                  input level_byte, input received_sum, input computed_sum,
                  output ready);
endinterface

interface ufrc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/ufrc_in_queue.sv]
// Front end: accepts input items, classifies them as byte or idle gap, and queues them.
// Depends on ufrc_pkg for the queued item type.
module ufrc_in_queue #(
    parameter int DEPTH = ufrc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_action,
    input  logic [7:0]       i_rx_byte,
    output logic             o_ready,
    output ufrc_pkg::t_qhead o_head,
    input  logic             i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ufrc_pkg::t_qitem r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    ufrc_pkg::t_qitem w_item;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != FULL_CNT);
    assign w_push = i_valid && o_ready;
    assign w_pop = i_pop && (r_count != '0);
    assign w_item.kind = i_action ? ufrc_pkg::KIND_IDLE : ufrc_pkg::KIND_BYTE;
    assign w_item.data = i_rx_byte;
    assign o_head.valid = (r_count != '0);
    assign o_head.item = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

[src/ufrc_parser.sv]
// Back end: frame state machine that consumes queued items and registers one status result.
// Depends on ufrc_pkg for phases, status codes, item and result types.
module ufrc_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_max_len,
    input  ufrc_pkg::t_qhead i_head,
    output logic             o_pop,
    output logic             o_res_valid,
    output ufrc_pkg::t_result o_res,
    input  logic             i_res_ready
);

    localparam int CW = ufrc_pkg::CNT_W;
    localparam int CAP_IW = $clog2(ufrc_pkg::CAP_DEPTH);
    localparam logic [CW-1:0] HDR_CNT = CW'(ufrc_pkg::HDR_LEN);
    localparam logic [CW-1:0] SUM_CNT = CW'(ufrc_pkg::SUM_START);

    ufrc_pkg::t_phase  r_phase, n_phase;
    logic [CW-1:0]     r_count, n_count;
    logic [7:0]        r_sum, n_sum;
    logic [7:0]        r_cap [ufrc_pkg::CAP_DEPTH];
    logic [7:0]        n_cap [ufrc_pkg::CAP_DEPTH];
    logic              r_out_vld, n_out_vld;
    ufrc_pkg::t_result r_out, n_out;

    logic [7:0]        v_cap [ufrc_pkg::CAP_DEPTH];
    logic [7:0]        v_sum;
    logic [CW-1:0]     v_count;
    logic              v_emit;
    logic              v_restart;
    ufrc_pkg::t_status v_status;
    logic [7:0]        v_rsum;
    logic              w_idle;
    logic [7:0]        w_b;

    assign o_pop = i_head.valid && (!r_out_vld || i_res_ready);
    assign w_idle = (i_head.item.kind == ufrc_pkg::KIND_IDLE);
    assign w_b = i_head.item.data;
    assign o_res_valid = r_out_vld;
    assign o_res = r_out;

    always_comb begin
        v_cap = r_cap;
        v_sum = r_sum;
        v_count = r_count;
        v_emit = 1'b0;
        v_restart = 1'b0;
        v_status = ufrc_pkg::ST_OK;
        v_rsum = 8'd0;
        n_phase = r_phase;
        unique case (r_phase)
            ufrc_pkg::PH_HEADER: begin
                if (w_idle) begin
                    if (r_count != '0) begin
                        v_emit = 1'b1;
                        v_status = ufrc_pkg::ST_HDR_TMO;
                        v_restart = 1'b1;
                    end
                end else begin
                    v_cap[r_count[CAP_IW-1:0]] = w_b;
                    if (r_count >= SUM_CNT) begin
                        v_sum = r_sum + w_b;
                    end
                    v_count = r_count + 1'b1;
                    if (v_count == HDR_CNT) begin
                        if (v_cap[0] != ufrc_pkg::SYNC_BYTE_0 ||
                            v_cap[1] != ufrc_pkg::SYNC_BYTE_1) begin
                            v_emit = 1'b1;
                            v_status = ufrc_pkg::ST_BAD_HDR;
                            n_phase = ufrc_pkg::PH_DRAIN;
                        end else if (v_cap[5] > i_max_len) begin
                            v_emit = 1'b1;
                            v_status = ufrc_pkg::ST_LEN_LONG;
                            n_phase = ufrc_pkg::PH_DRAIN;
                        end else begin
                            n_phase = ufrc_pkg::PH_BODY;
                        end
                    end
                end
            end
            ufrc_pkg::PH_BODY: begin
                if (w_idle) begin
                    v_emit = 1'b1;
                    v_status = ufrc_pkg::ST_BODY_TMO;
                    v_restart = 1'b1;
                end else if (r_count < (HDR_CNT + {1'b0, r_cap[5]})) begin
                    if (r_count == HDR_CNT) begin
                        v_cap[6] = w_b;
                    end else if (r_count == HDR_CNT + 1'b1) begin
                        v_cap[7] = w_b;
                    end
                    v_sum = r_sum + w_b;
                    v_count = r_count + 1'b1;
                end else begin
                    v_emit = 1'b1;
                    v_status = (w_b == r_sum) ? ufrc_pkg::ST_OK : ufrc_pkg::ST_SUM_BAD;
                    v_rsum = w_b;
                    n_phase = ufrc_pkg::PH_DRAIN;
                end
            end
            default: begin
                if (w_idle) begin
                    v_restart = 1'b1;
                end
            end
        endcase

        n_out.status = v_status;
        n_out.version_hi = v_cap[2];
        n_out.version_lo = v_cap[3];
        n_out.frame_type = v_cap[4];
        n_out.payload_len = v_cap[5];
        n_out.power_byte = v_cap[6];
        n_out.level_byte = v_cap[7];
        n_out.received_sum = v_rsum;
        n_out.computed_sum = v_sum;

        if (v_restart) begin
            n_phase = ufrc_pkg::PH_HEADER;
            n_count = '0;
            n_sum = 8'd0;
            for (int i = 0; i < ufrc_pkg::CAP_DEPTH; i++) begin
                n_cap[i] = 8'd0;
            end
        end else begin
            n_count = v_count;
            n_sum = v_sum;
            n_cap = v_cap;
        end

        if (o_pop && v_emit) begin
            n_out_vld = 1'b1;
        end else if (i_res_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ufrc_pkg::PH_HEADER;
            r_count <= '0;
            r_sum <= 8'd0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < ufrc_pkg::CAP_DEPTH; i++) begin
                r_cap[i] <= 8'd0;
            end
        end else begin
            r_out_vld <= n_out_vld;
            if (o_pop) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_sum <= n_sum;
                r_cap <= n_cap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && v_emit) begin
            r_out <= n_out;
        end
    end

endmodule

[src/uart_frame_receiver_checksum_core.sv]
// Top level of the UART frame receiver: input queue, frame parser and configuration register.
// Depends on ufrc_pkg, the channel interfaces, ufrc_in_queue and ufrc_parser.
//
// Accepts one received byte or idle-gap event per clock and gives at most one status result
// per frame: ok, bad header, length too long, checksum mismatch, header or body timeout.
// Frames are AA 55, two version bytes, a type byte, a length byte, the payload and an 8-bit
// additive checksum over bytes 2 through the last payload byte. After a result other than a
// timeout, bytes are dropped until an idle gap. The parser takes one item per cycle while
// no result waits to be taken; a result is registered from the item that completes it, after
// that item has passed through the input queue. The input queue of QUEUE_DEPTH items lets the
// input keep moving while a result waits to be taken, and input stalls only when that queue
// is full. The payload length limit register resets to 10 and accepts a write in every cycle.
module uart_frame_receiver_checksum_core #(
    parameter int QUEUE_DEPTH = ufrc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ufrc_item_if.sink     i_item,
    ufrc_cfg_if.sink      i_cfg,
    ufrc_result_if.source o_result
);

    logic [7:0]        r_max_len;
    ufrc_pkg::t_qhead  w_head;
    logic              w_pop;
    logic              w_res_valid;
    ufrc_pkg::t_result w_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= ufrc_pkg::MAX_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_max_len <= i_cfg.data;
        end
    end

    ufrc_in_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_item.valid),
        .i_action  (i_item.action),
        .i_rx_byte (i_item.rx_byte),
        .o_ready   (i_item.ready),
        .o_head    (w_head),
        .i_pop     (w_pop)
    );

    ufrc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_len   (r_max_len),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (o_result.ready)
    );

    assign o_result.valid = w_res_valid;
    assign o_result.status = w_res.status;
    assign o_result.version_hi = w_res.version_hi;
    assign o_result.version_lo = w_res.version_lo;
    assign o_result.frame_type = w_res.frame_type;
    assign o_result.payload_len = w_res.payload_len;
    assign o_result.power_byte = w_res.power_byte;
    assign o_result.level_byte = w_res.level_byte;
    assign o_result.received_sum = w_res.received_sum;
    assign o_result.computed_sum = w_res.computed_sum;

`ifndef NO_ASSERTIONS
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("Parser consumed an item from an empty queue.");

    a_no_pop_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.ready) |-> !w_pop)
        else $error("Parser advanced while a result was waiting.");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.status != 3'd6 && o_result.status != 3'd7))
        else $error("Result carries an undefined status code.");

    a_sum_only_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status != ufrc_pkg::ST_OK &&
         o_result.status != ufrc_pkg::ST_SUM_BAD) |-> (o_result.received_sum == 8'd0))
        else $error("Received checksum reported for a frame that never reached it.");
`endif

endmodule

[tb/sv/ufrc_frame_checker.sv]
// Frame status checker for the UART frame receiver: watches the item, limit and result channels,
// predicts the status report of every frame and compares each returned report field by field.
// Depends on ufrc_pkg and the channel interfaces in ufrc_if.sv.
module ufrc_frame_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ufrc_item_if    i_item,
    ufrc_cfg_if     i_cfg,
    ufrc_result_if  i_result,
    output int      o_fail_count,
    output int      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ufrc_pkg::*;

    t_phase     fr_phase;
    logic [8:0] fr_count;
    logic [7:0] fr_sum;
    logic [7:0] fr_bytes [CAP_DEPTH];
    logic [7:0] len_limit;
    t_result    frame_reports_q [$];

    function automatic void clear_frame();
        fr_phase = PH_HEADER;
        fr_count = '0;
        fr_sum = '0;
        foreach (fr_bytes[i]) fr_bytes[i] = '0;
    endfunction

    function automatic t_result make_report(input t_status st, input logic [7:0] rsum);
        t_result rep;
        rep.status = st;
        rep.version_hi = fr_bytes[2];
        rep.version_lo = fr_bytes[3];
        rep.frame_type = fr_bytes[4];
        rep.payload_len = fr_bytes[5];
        rep.power_byte = fr_bytes[6];
        rep.level_byte = fr_bytes[7];
        rep.received_sum = rsum;
        rep.computed_sum = fr_sum;
        return rep;
    endfunction

    function automatic bit predict_frame_step(input t_kind kind, input logic [7:0] b,
                                              output t_result rep);
        rep = '0;
        if (fr_phase == PH_HEADER) begin
            if (kind == KIND_IDLE) begin
                if (fr_count == 0) return 1'b0;
                rep = make_report(ST_HDR_TMO, 8'h00);
                clear_frame();
                return 1'b1;
            end
            if (fr_count < HDR_LEN) fr_bytes[fr_count] = b;
            if (fr_count >= SUM_START) fr_sum = fr_sum + b;
            fr_count = fr_count + 1'b1;
            if (fr_count < HDR_LEN) return 1'b0;
            if (fr_bytes[0] != SYNC_BYTE_0 || fr_bytes[1] != SYNC_BYTE_1) begin
                fr_phase = PH_DRAIN;
                rep = make_report(ST_BAD_HDR, 8'h00);
                return 1'b1;
            end
            if (fr_bytes[5] > len_limit) begin
                fr_phase = PH_DRAIN;
                rep = make_report(ST_LEN_LONG, 8'h00);
                return 1'b1;
            end
            fr_phase = PH_BODY;
            return 1'b0;
        end
        if (fr_phase == PH_BODY) begin
            if (kind == KIND_IDLE) begin
                rep = make_report(ST_BODY_TMO, 8'h00);
                clear_frame();
                return 1'b1;
            end
            if (int'(fr_count) < HDR_LEN + int'(fr_bytes[5])) begin
                if (fr_count == HDR_LEN) fr_bytes[6] = b;
                else if (fr_count == HDR_LEN + 1) fr_bytes[7] = b;
                fr_sum = fr_sum + b;
                fr_count = fr_count + 1'b1;
                return 1'b0;
            end
            fr_phase = PH_DRAIN;
            rep = make_report((b == fr_sum) ? ST_OK : ST_SUM_BAD, b);
            return 1'b1;
        end
        if (kind == KIND_IDLE) clear_frame();
        return 1'b0;
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result rep;
        if (!i_rst_n) begin
            len_limit = MAX_LEN_RESET;
            clear_frame();
            frame_reports_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) len_limit = i_cfg.data;
            if (i_result.valid && i_result.ready) begin
                if (frame_reports_q.size() == 0) begin
                    $display("%0t: unexpected report, expected none, actual status %0d",
                             $time, i_result.status);
                    o_fail_count++;
                end else begin
                    want = frame_reports_q.pop_front();
                    check_field("status", 8'(want.status), 8'(i_result.status));
                    check_field("version_hi", want.version_hi, i_result.version_hi);
                    check_field("version_lo", want.version_lo, i_result.version_lo);
                    check_field("frame_type", want.frame_type, i_result.frame_type);
                    check_field("payload_len", want.payload_len, i_result.payload_len);
                    check_field("power_byte", want.power_byte, i_result.power_byte);
                    check_field("level_byte", want.level_byte, i_result.level_byte);
                    check_field("received_sum", want.received_sum, i_result.received_sum);
                    check_field("computed_sum", want.computed_sum, i_result.computed_sum);
                end
            end
            if (i_item.valid && i_item.ready) begin
                if (predict_frame_step(t_kind'(i_item.action), i_item.rx_byte, rep))
                    frame_reports_q.push_back(rep);
            end
        end
        o_pending = frame_reports_q.size();
    end

endmodule

[tb/sv/tb_uart_frame_receiver_checksum_core.sv]
// Top of the UART frame receiver testbench: clock, reset, frame stimulus and result back-pressure.
// Depends on ufrc_pkg, the channel interfaces, the block and ufrc_frame_checker.
module tb_uart_frame_receiver_checksum_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ufrc_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int PHASE_ITEMS = 230;
    localparam int LONG_HOLD = 200;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int NUM_DIRECTED = 34;
    localparam logic [8:0] IDLE_EV = {KIND_IDLE, 8'h00};

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   items_sent;
    bit   no_gaps;
    bit   hold_req;
    bit   holding;
    logic [7:0] len_limit;

    logic [8:0] directed_seq [NUM_DIRECTED] = '{
        IDLE_EV,
        9'h0AA, 9'h055, IDLE_EV,
        9'h000, 9'h0FF, 9'h000, 9'h0FF, 9'h000, 9'h0FF, 9'h07E, {KIND_IDLE, 8'hFF},
        9'h0AA, 9'h055, 9'h080, 9'h07F, 9'h001, 9'h00B, IDLE_EV,
        9'h0AA, 9'h055, 9'h0FF, 9'h0FF, 9'h0FF, 9'h000, 9'h0FD, IDLE_EV,
        9'h0AA, 9'h055, 9'h000, 9'h000, 9'h000, 9'h001, IDLE_EV
    };
    int limit_plan [6] = '{0, 255, 3, -1, 10, -1};

    ufrc_item_if   item_ch ();
    ufrc_cfg_if    cfg_ch ();
    ufrc_result_if result_ch ();

    uart_frame_receiver_checksum_core dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    ufrc_frame_checker frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (item_ch),
        .i_cfg        (cfg_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_item(input t_kind kind, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.action <= kind;
        item_ch.rx_byte <= b;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_for_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        len_limit = v;
    endtask

    task automatic send_frame(input int force_len);
        logic [7:0] hdr [HDR_LEN];
        logic [7:0] sum;
        logic [7:0] b;
        int kind;
        int r;
        int len;
        int lim_small;
        int lim_mid;
        int cut;
        int body_cut;
        bit rejected;
        kind = $urandom_range(0, 99);
        if (kind < 10 && force_len < 0) begin
            repeat ($urandom_range(1, 8))
                push_item(($urandom_range(0, 3) == 0) ? KIND_IDLE : KIND_BYTE, 8'($urandom));
            return;
        end
        if ($urandom_range(0, 9) == 0) push_item(KIND_IDLE, 8'($urandom));
        hdr[0] = SYNC_BYTE_0;
        hdr[1] = SYNC_BYTE_1;
        if (kind < 22 && force_len < 0) begin
            if ($urandom_range(0, 1) == 1) begin
                hdr[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            end else begin
                hdr[0] = 8'($urandom);
                hdr[1] = 8'($urandom);
            end
        end
        for (int i = 2; i < 5; i++) hdr[i] = 8'($urandom);
        lim_small = (len_limit < 6) ? int'(len_limit) : 6;
        lim_mid = (len_limit < 24) ? int'(len_limit) : 24;
        r = $urandom_range(0, 99);
        if (force_len >= 0) len = force_len;
        else if (r < 60) len = $urandom_range(0, lim_small);
        else if (r < 85) len = $urandom_range(0, lim_mid);
        else if (r < 90) len = (len_limit <= 24) ? int'(len_limit) : lim_mid;
        else if (r < 91) len = len_limit;
        else if (len_limit == 8'd255) len = $urandom_range(0, lim_small);
        else len = $urandom_range(int'(len_limit) + 1, 255);
        hdr[5] = 8'(len);
        sum = hdr[2] + hdr[3] + hdr[4] + hdr[5];
        rejected = (hdr[0] != SYNC_BYTE_0) || (hdr[1] != SYNC_BYTE_1) || (hdr[5] > len_limit);
        r = (force_len >= 0) ? 99 : $urandom_range(0, 99);
        cut = (r < 8) ? $urandom_range(1, HDR_LEN - 1) : HDR_LEN;
        body_cut = (r >= 8 && r < 16 && len > 0) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < cut; i++) push_item(KIND_BYTE, hdr[i]);
        if (cut == HDR_LEN && !rejected) begin
            for (int i = 0; i < body_cut; i++) begin
                b = 8'($urandom);
                sum = sum + b;
                push_item(KIND_BYTE, b);
            end
            if (body_cut == len)
                push_item(KIND_BYTE, ($urandom_range(0, 3) == 0) ?
                          sum ^ 8'($urandom_range(1, 255)) : sum);
        end
        if (cut == HDR_LEN && (rejected || body_cut == len))
            repeat ($urandom_range(0, 2)) push_item(KIND_BYTE, 8'($urandom));
        push_item(KIND_IDLE, 8'($urandom));
    endtask

    initial begin : report_receiver
        int stall;
        int run;
        result_ch.ready <= 1'b0;
        forever begin
            if (hold_req) begin
                result_ch.ready <= 1'b0;
                holding = 1'b1;
                hold_req = 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holding = 1'b0;
            end
            stall = pick_gap();
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clk);
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int phase_end;
        item_ch.valid <= 1'b0;
        item_ch.action <= KIND_BYTE;
        item_ch.rx_byte <= 8'h00;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= 8'h00;
        rst_n <= 1'b0;
        len_limit = MAX_LEN_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_seq[i])
            push_item(t_kind'(directed_seq[i][8]), directed_seq[i][7:0]);
        foreach (limit_plan[ph]) begin
            wait_for_results();
            write_limit((limit_plan[ph] < 0) ? 8'($urandom_range(0, 255)) : 8'(limit_plan[ph]));
            if (ph == 0) begin
                hold_req = 1'b1;
                wait (holding);
                @(posedge clk);
                no_gaps = 1'b1;
                repeat (8) begin
                    push_item(KIND_BYTE, 8'h00);
                    repeat (HDR_LEN - 1) push_item(KIND_BYTE, 8'($urandom));
                    push_item(KIND_IDLE, 8'h00);
                end
            end
            no_gaps = (ph == 3);
            if (ph == 1) send_frame(255);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) send_frame(-1);
        end
        wait_for_results();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[uart_frame_receiver_checksum_core.f]
src/ufrc_pkg.sv
src/ufrc_if.sv
src/ufrc_in_queue.sv
src/ufrc_parser.sv
src/uart_frame_receiver_checksum_core.sv
tb/sv/ufrc_frame_checker.sv
tb/sv/tb_uart_frame_receiver_checksum_core.sv
